// ----- hdl/asched_pkg.sv -----
`timescale 1ns / 1ps

package asched_pkg;

  // Slots per queue; the first queue owns slots 0..QueueDepth-1, the second the rest.
  localparam int QueueDepth = 4;
  localparam int NumSlots   = 2 * QueueDepth;
  localparam int SlotIdxW   = $clog2(NumSlots);
  localparam int QIdxW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);

  // Command queue between front and back
  localparam int CmdFifoDepth = 2;
  localparam int CmdPtrW      = (CmdFifoDepth > 1) ? $clog2(CmdFifoDepth) : 1;
  localparam int CmdCntW      = $clog2(CmdFifoDepth + 1);

  localparam logic StartFirstReset = 1'b1;

  localparam logic [7:0] PrioLimit   = 8'd140;
  localparam logic [7:0] PrioHigh    = 8'd100;
  localparam logic [4:0] ScaleHigh   = 5'd20;
  localparam logic [4:0] ScaleLow    = 5'd5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_RUN    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_DROPPED = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

  typedef struct packed {
    op_e   op;
    logic  target;
    slot_t proc;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  ran_id;
    logic [7:0]  ran_priority;
    logic [11:0] quantum;
    logic [15:0] burst_left;
    logic        finished;
    logic        serving_first_now;
  } res_t;

endpackage

// ----- hdl/active_expired_priority_scheduler.sv -----
`timescale 1ns / 1ps

// Two-queue priority scheduler. Each transfer on the input channel is an
// insert or a run step; a run step scans the served queue one slot per
// cycle through the slot RAM's single read port, then computes the quantum
// and writes back. A two-entry command queue lets the next items be taken
// while one is being executed, and the result register holds a finished
// result until the output transfer, so either side can stall independently.
// The config write loads the queue to serve next; issue it only while idle.
module active_expired_priority_scheduler
  import asched_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic        target_queue_i,
  input  logic [7:0]  proc_id_i,
  input  logic [7:0]  proc_priority_i,
  input  logic [15:0] proc_burst_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  ran_id_o,
  output logic [7:0]  ran_priority_o,
  output logic [11:0] quantum_o,
  output logic [15:0] burst_left_o,
  output logic        finished_o,
  output logic        serving_first_now_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  res_t res;

  assign cfg_ready_o = 1'b1;

  asched_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .target_queue_i  (target_queue_i),
    .proc_id_i       (proc_id_i),
    .proc_priority_i (proc_priority_i),
    .proc_burst_i    (proc_burst_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  asched_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_we_i    (cfg_valid_i),
    .cfg_first_i (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign status_o            = res.status;
  assign ran_id_o            = res.ran_id;
  assign ran_priority_o      = res.ran_priority;
  assign quantum_o           = res.quantum;
  assign burst_left_o        = res.burst_left;
  assign finished_o          = res.finished;
  assign serving_first_now_o = res.serving_first_now;

endmodule

// ----- hdl/asched_ram.sv -----
`timescale 1ns / 1ps

module asched_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/asched_front.sv -----
`timescale 1ns / 1ps

module asched_front
  import asched_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic        target_queue_i,
  input  logic [7:0]  proc_id_i,
  input  logic [7:0]  proc_priority_i,
  input  logic [15:0] proc_burst_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t               fifo_q [CmdFifoDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdCntW-1:0] count_q, count_d;
  logic               push;
  logic               pop;
  cmd_t               cmd_in;

  function automatic logic [CmdPtrW-1:0] ptr_next(input logic [CmdPtrW-1:0] ptr);
    ptr_next = (ptr == CmdPtrW'(CmdFifoDepth - 1)) ? '0 : ptr + CmdPtrW'(1);
  endfunction

  always_comb begin
    cmd_in.op         = opcode_i ? OP_RUN : OP_INSERT;
    cmd_in.target     = target_queue_i;
    cmd_in.proc.id    = proc_id_i;
    cmd_in.proc.prio  = proc_priority_i;
    cmd_in.proc.burst = proc_burst_i;
  end

  assign in_ready_o  = (count_q != CmdCntW'(CmdFifoDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CmdCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CmdCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- hdl/asched_back.sv -----
`timescale 1ns / 1ps

module asched_back
  import asched_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic cfg_we_i,
  input  logic cfg_first_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_CALC   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [NumSlots-1:0]   valid_q, valid_d;
  logic                  serving_first_q, serving_first_d;
  cmd_t                  cmd_q, cmd_d;
  logic [CntW-1:0]       scan_cnt_q, scan_cnt_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [SlotIdxW-1:0]   chk_slot_q, chk_slot_d;
  logic                  found_q, found_d;
  logic [SlotIdxW-1:0]   best_slot_q, best_slot_d;
  slot_t                 best_q, best_d;
  logic [11:0]           quantum_q, quantum_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  res_q, res_d;

  logic                  ram_we;
  logic [SlotIdxW-1:0]   ram_waddr;
  slot_t                 ram_wdata;
  logic [SlotIdxW-1:0]   ram_raddr;
  logic [SlotW-1:0]      ram_rdata;
  slot_t                 rd_slot;

  logic                  srv_q;
  logic                  out_free;
  logic [7:0]            prio_gap;
  logic [15:0]           remain;
  logic                  free_found;
  logic [SlotIdxW-1:0]   free_slot;
  logic                  put_q;
  logic                  srv_empty;

  function automatic logic [SlotIdxW-1:0] slot_of(input logic q, input logic [QIdxW-1:0] off);
    slot_of = SlotIdxW'(off) + (q ? SlotIdxW'(QueueDepth) : '0);
  endfunction

  assign srv_q    = ~serving_first_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign rd_slot  = slot_t'(ram_rdata);
  assign prio_gap = PrioLimit - best_q.prio;
  assign remain   = best_q.burst - 16'(quantum_q);
  assign ram_raddr = slot_of(srv_q, scan_cnt_q[QIdxW-1:0]);

  // queue that receives a write on commit: insert target or the requeue side
  assign put_q = (cmd_q.op == OP_RUN) ? ~srv_q : cmd_q.target;

  // lowest free slot of the receiving queue
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (!free_found && !valid_q[slot_of(put_q, QIdxW'(i))]) begin
        free_found = 1'b1;
        free_slot  = slot_of(put_q, QIdxW'(i));
      end
    end
  end

  always_comb begin
    state_d         = state_q;
    valid_d         = valid_q;
    serving_first_d = serving_first_q;
    cmd_d           = cmd_q;
    scan_cnt_d      = scan_cnt_q;
    chk_vld_d       = 1'b0;
    chk_slot_d      = chk_slot_q;
    found_d         = found_q;
    best_slot_d     = best_slot_q;
    best_d          = best_q;
    quantum_d       = quantum_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    res_d           = res_q;
    cmd_pop_o       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = free_slot;
    ram_wdata       = cmd_q.proc;
    srv_empty       = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          serving_first_d = cfg_first_i;
        end
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          found_d    = 1'b0;
          scan_cnt_d = '0;
          state_d    = (cmd_i.op == OP_RUN) ? S_SCAN : S_COMMIT;
        end
      end

      S_SCAN: begin
        // read data arrives in the cycle after its address is issued
        if (chk_vld_q && valid_q[chk_slot_q] && (!found_q || rd_slot.prio < best_q.prio)) begin
          found_d     = 1'b1;
          best_slot_d = chk_slot_q;
          best_d      = rd_slot;
        end
        if (scan_cnt_q < CntW'(QueueDepth)) begin
          chk_vld_d  = 1'b1;
          chk_slot_d = ram_raddr;
          scan_cnt_d = scan_cnt_q + CntW'(1);
        end else begin
          state_d = S_CALC;
        end
      end

      S_CALC: begin
        if (best_q.prio >= PrioLimit) begin
          quantum_d = '0;
        end else if (best_q.prio < PrioHigh) begin
          quantum_d = 12'(prio_gap) * 12'(ScaleHigh);
        end else begin
          quantum_d = 12'(prio_gap) * 12'(ScaleLow);
        end
        state_d = S_COMMIT;
      end

      S_COMMIT: begin
        if (out_free) begin
          res_d.status       = ST_OK;
          res_d.ran_id       = '0;
          res_d.ran_priority = '0;
          res_d.quantum      = '0;
          res_d.burst_left   = '0;
          res_d.finished     = 1'b0;
          if (cmd_q.op == OP_INSERT) begin
            if (free_found) begin
              ram_we              = 1'b1;
              valid_d[free_slot]  = 1'b1;
            end else begin
              res_d.status = ST_FULL;
            end
          end else begin
            if (!found_q) begin
              res_d.status = ST_EMPTY;
            end else begin
              valid_d[best_slot_q] = 1'b0;
              res_d.ran_id         = best_q.id;
              res_d.ran_priority   = best_q.prio;
              res_d.quantum        = quantum_q;
              if (best_q.burst > 16'(quantum_q)) begin
                res_d.burst_left = remain;
                ram_wdata.id     = best_q.id;
                ram_wdata.prio   = best_q.prio;
                ram_wdata.burst  = remain;
                if (free_found) begin
                  ram_we             = 1'b1;
                  valid_d[free_slot] = 1'b1;
                end else begin
                  res_d.status = ST_DROPPED;
                end
              end else begin
                res_d.finished = 1'b1;
              end
            end
            // served queue drained: switch sides
            for (int i = 0; i < QueueDepth; i++) begin
              if (valid_d[slot_of(srv_q, QIdxW'(i))]) begin
                srv_empty = 1'b0;
              end
            end
            if (srv_empty) begin
              serving_first_d = ~serving_first_q;
            end
          end
          res_d.serving_first_now = serving_first_d;
          out_valid_d             = 1'b1;
          state_d                 = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      valid_q         <= '0;
      serving_first_q <= StartFirstReset;
      out_valid_q     <= 1'b0;
      scan_cnt_q      <= '0;
      chk_vld_q       <= 1'b0;
      found_q         <= 1'b0;
    end else begin
      state_q         <= state_d;
      valid_q         <= valid_d;
      serving_first_q <= serving_first_d;
      out_valid_q     <= out_valid_d;
      scan_cnt_q      <= scan_cnt_d;
      chk_vld_q       <= chk_vld_d;
      found_q         <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    chk_slot_q  <= chk_slot_d;
    best_slot_q <= best_slot_d;
    best_q      <= best_d;
    quantum_q   <= quantum_d;
    res_q       <= res_d;
  end

  asched_ram #(
    .Width (SlotW),
    .Depth (NumSlots)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (SlotW'(ram_wdata)),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
